### rtl/uets_pkg.sv
package uets_pkg;

	// Fixed sizes of the slot table and the packet limit
	localparam int NUM_SLOTS  = 32;
	localparam int MAX_PACKET = 64;
	localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Field widths
	localparam int OP_W   = 2;
	localparam int SLOT_W = 5;
	localparam int LEN_W  = 16;
	localparam int PKT_W  = 7;

	// Register reset value
	localparam logic [PKT_W-1:0] MPS_RESET = 7'd64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_START      = 2'd0;
	localparam logic [OP_W-1:0] OP_PKT_DONE   = 2'd1;
	localparam logic [OP_W-1:0] OP_FORCE_DATA1 = 2'd2;

	// Status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_BUSY = 1'b1;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [SLOT_W-1:0] endpoint_slot;
		logic [LEN_W-1:0]  request_length;
		logic [PKT_W-1:0]  actual_length;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic              issue_packet;
		logic [PKT_W-1:0]  packet_length;
		logic              packet_pid;
		logic              packet_full;
		logic              packet_last;
		logic              transfer_done;
		logic [LEN_W-1:0]  done_length;
	} result_t;

	// Queue head handed to the back part
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

### rtl/uets_front.sv
module uets_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  uets_pkg::cmd_t cmd,
	output uets_pkg::qhead_t head,
	input  logic           pop
);
	import uets_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;

	assign busy   = (count_q == QCNT_W'(QDEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// payload store, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/uets_back.sv
module uets_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  uets_pkg::qhead_t            head,
	output logic                        pop,
	input  logic [uets_pkg::PKT_W-1:0]  max_packet_size,
	output logic                        result_strobe,
	output uets_pkg::result_t           result
);
	import uets_pkg::*;

	logic             busy_q   [NUM_SLOTS];
	logic [LEN_W-1:0] total_q  [NUM_SLOTS];
	logic [LEN_W-1:0] moved_q  [NUM_SLOTS];
	logic             toggle_q [NUM_SLOTS];

	logic                  strobe_s1;
	result_t               result_s1;

	logic [SLOT_IDX_W-1:0] idx;
	logic                  in_range;
	logic                  act;
	logic                  cur_busy;
	logic [LEN_W-1:0]      cur_total;
	logic [LEN_W-1:0]      cur_moved;
	logic                  cur_toggle;
	logic [PKT_W-1:0]      mps;
	logic [LEN_W:0]        sum;
	logic [LEN_W-1:0]      sat_sum;
	logic [LEN_W-1:0]      iss_total;
	logic [LEN_W-1:0]      iss_moved;
	logic [LEN_W-1:0]      remaining;
	logic [PKT_W-1:0]      len;
	logic                  last;
	logic                  wr;
	logic                  nxt_busy;
	logic [LEN_W-1:0]      nxt_total;
	logic [LEN_W-1:0]      nxt_moved;
	logic                  nxt_toggle;
	result_t               res;

	// back part never stalls: take the head whenever there is one
	assign pop = head.valid;
	assign act = head.valid && in_range;

	assign idx      = head.cmd.endpoint_slot[SLOT_IDX_W-1:0];
	assign in_range = (int'(head.cmd.endpoint_slot) < NUM_SLOTS);

	assign cur_busy   = busy_q[idx];
	assign cur_total  = total_q[idx];
	assign cur_moved  = moved_q[idx];
	assign cur_toggle = toggle_q[idx];

	// effective packet size: zero acts as one, capped at the build limit
	always_comb begin
		if (max_packet_size == '0) begin
			mps = PKT_W'(1);
		end else if (int'(max_packet_size) > MAX_PACKET) begin
			mps = PKT_W'(MAX_PACKET);
		end else begin
			mps = max_packet_size;
		end
	end

	assign sum     = {1'b0, cur_moved} + (LEN_W+1)'(head.cmd.actual_length);
	assign sat_sum = sum[LEN_W] ? '1 : sum[LEN_W-1:0];

	// packet sizing, shared by start and continue
	assign iss_total = (head.cmd.operation == OP_START) ? head.cmd.request_length : cur_total;
	assign iss_moved = (head.cmd.operation == OP_START) ? '0 : sat_sum;
	assign remaining = (iss_moved < iss_total) ? (iss_total - iss_moved) : '0;
	assign len       = (remaining < LEN_W'(mps)) ? remaining[PKT_W-1:0] : mps;
	assign last      = (({1'b0, iss_moved} + (LEN_W+1)'(len)) >= {1'b0, iss_total});

	always_comb begin
		res        = '0;
		wr         = 1'b0;
		nxt_busy   = cur_busy;
		nxt_total  = cur_total;
		nxt_moved  = cur_moved;
		nxt_toggle = cur_toggle;
		if (act) begin
			unique case (head.cmd.operation)
				OP_START: begin
					if (cur_busy) begin
						res.status = STATUS_BUSY;
					end else begin
						wr                = 1'b1;
						nxt_busy          = 1'b1;
						nxt_total         = head.cmd.request_length;
						nxt_moved         = '0;
						nxt_toggle        = ~cur_toggle;
						res.status        = STATUS_OK;
						res.issue_packet  = 1'b1;
						res.packet_length = len;
						res.packet_pid    = cur_toggle;
						res.packet_full   = ~head.cmd.endpoint_slot[0];
						res.packet_last   = last;
					end
				end
				OP_PKT_DONE: begin
					if (cur_busy) begin
						wr = 1'b1;
						if ((sat_sum >= cur_total) || (head.cmd.actual_length < mps)) begin
							nxt_busy          = 1'b0;
							nxt_total         = '0;
							nxt_moved         = '0;
							res.transfer_done = 1'b1;
							res.done_length   = sat_sum;
						end else begin
							nxt_moved         = sat_sum;
							nxt_toggle        = ~cur_toggle;
							res.issue_packet  = 1'b1;
							res.packet_length = len;
							res.packet_pid    = cur_toggle;
							res.packet_full   = ~head.cmd.endpoint_slot[0];
							res.packet_last   = last;
						end
					end
				end
				OP_FORCE_DATA1: begin
					wr         = 1'b1;
					nxt_toggle = 1'b1;
				end
				default: begin
					wr = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				busy_q[i]   <= 1'b0;
				total_q[i]  <= '0;
				moved_q[i]  <= '0;
				toggle_q[i] <= 1'b0;
			end
		end else if (wr) begin
			busy_q[idx]   <= nxt_busy;
			total_q[idx]  <= nxt_total;
			moved_q[idx]  <= nxt_moved;
			toggle_q[idx] <= nxt_toggle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s1 <= res;
	end

	assign result_strobe = strobe_s1;
	assign result        = result_s1;

endmodule

### rtl/usb_endpoint_transfer_segmenter.sv
// Channel   Ports                         Handshake
// -------   ---------------------------   ----------------------------------------
// command   start, busy, cmd              taken at an edge with start high, busy low
// result    result_strobe, result         one cycle per item, cannot be held off
// config    cfg_wen, cfg_wdata            written at an edge with cfg_wen high
//
// Sustains one item per cycle; every item gives one result, registered through
// one queue stage and one slot read-modify-write stage.
// The slot table is one read-modify-write port, which sets that single-cycle rate.
// Reset clears the slot table and the queue at once and sets max packet to 64.
// busy rises only when the two-entry command queue is full; with the back part
// draining one item a cycle it stays low in practice.
module usb_endpoint_transfer_segmenter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  uets_pkg::cmd_t             cmd,
	input  logic                       cfg_wen,
	input  logic [uets_pkg::PKT_W-1:0] cfg_wdata,
	output logic                       result_strobe,
	output uets_pkg::result_t          result
);
	import uets_pkg::*;

	// shared max packet size register
	logic [PKT_W-1:0] mps_q;
	qhead_t           head;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mps_q <= MPS_RESET;
		end else if (cfg_wen) begin
			mps_q <= cfg_wdata;
		end
	end

	// front: take and hold each item in the queue
	uets_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.head   (head),
		.pop    (pop)
	);

	// back: update the slot and emit the result item
	uets_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.max_packet_size (mps_q),
		.result_strobe   (result_strobe),
		.result          (result)
	);

endmodule

### sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import uets_pkg::*;

	// The fourth operation code has no meaning and must be ignored by the block
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Cycles with neither an item taken, a result shown nor a register write
	// before the run is declared hung; the longest correct quiet stretch is
	// one sender burst of idle cycles plus the queue and result stages.
	localparam int STALL_LIMIT = 1000;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	cmd_t              cmd       = '0;
	logic              cfg_wen   = 1'b0;
	logic [PKT_W-1:0]  cfg_wdata = '0;
	logic              result_strobe;
	result_t           result;

	usb_endpoint_transfer_segmenter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.result_strobe (result_strobe),
		.result        (result)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the slot table and the packet size register
	// ------------------------------------------------------------------
	bit               slot_busy   [NUM_SLOTS];
	logic [LEN_W-1:0] slot_total  [NUM_SLOTS];
	logic [LEN_W-1:0] slot_moved  [NUM_SLOTS];
	bit               slot_toggle [NUM_SLOTS];
	logic [PKT_W-1:0] mps_reg;

	// Results owed by the block, oldest first
	result_t due_results [$];

	int unsigned items_sent       = 0;
	int unsigned results_checked  = 0;
	int unsigned transfers_done   = 0;
	int unsigned starts_refused   = 0;
	int unsigned counts_saturated = 0;
	int unsigned mps_writes       = 0;
	int unsigned mismatches       = 0;
	int unsigned quiet_cycles     = 0;

	function automatic void clear_slot_table();
		foreach (slot_busy[i]) begin
			slot_busy[i]   = 1'b0;
			slot_total[i]  = '0;
			slot_moved[i]  = '0;
			slot_toggle[i] = 1'b0;
		end
		mps_reg = MPS_RESET;
	endfunction

	// Register value 0 behaves as 1; anything above the build limit is clipped
	function automatic int unsigned eff_packet();
		int unsigned m;
		m = mps_reg;
		if (m == 0)
			m = 1;
		if (m > MAX_PACKET)
			m = MAX_PACKET;
		return m;
	endfunction

	// Length of the next packet on a slot: what is left, capped at the packet size
	function automatic int unsigned next_packet_len(input int unsigned s);
		int unsigned left;
		left = (slot_moved[s] < slot_total[s]) ? slot_total[s] - slot_moved[s] : 0;
		return (left < eff_packet()) ? left : eff_packet();
	endfunction

	// Fill in the packet fields and flip the data toggle
	function automatic void cut_packet(input int unsigned s, inout result_t r);
		int unsigned len;
		len = next_packet_len(s);
		r.issue_packet  = 1'b1;
		r.packet_length = PKT_W'(len);
		r.packet_pid    = slot_toggle[s];
		slot_toggle[s]  = ~slot_toggle[s];
		r.packet_full   = (s % 2 == 0);
		r.packet_last   = (slot_moved[s] + len >= slot_total[s]);
	endfunction

	// Work out the block's answer to one item and advance the shadow table
	function automatic result_t segment_command(input cmd_t item);
		result_t     r;
		int unsigned s;
		int unsigned sum;
		r = '0;
		s = item.endpoint_slot;
		if (s >= NUM_SLOTS)
			return r;
		case (item.operation)
			OP_START: begin
				if (slot_busy[s]) begin
					r.status = STATUS_BUSY;
					starts_refused++;
				end else begin
					slot_busy[s]  = 1'b1;
					slot_total[s] = item.request_length;
					slot_moved[s] = '0;
					cut_packet(s, r);
				end
			end
			OP_PKT_DONE: begin
				if (slot_busy[s]) begin
					sum = slot_moved[s] + item.actual_length;
					if (sum > 16'hFFFF) begin
						sum = 16'hFFFF;
						counts_saturated++;
					end
					slot_moved[s] = LEN_W'(sum);
					if (sum >= slot_total[s] || item.actual_length < eff_packet()) begin
						// count reached or short packet: finish, keep the toggle
						r.transfer_done = 1'b1;
						r.done_length   = LEN_W'(sum);
						slot_busy[s]    = 1'b0;
						slot_total[s]   = '0;
						slot_moved[s]   = '0;
						transfers_done++;
					end else begin
						cut_packet(s, r);
					end
				end
			end
			OP_FORCE_DATA1: slot_toggle[s] = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Take each strobed result at the edge that ends its cycle
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_strobe === 1'b1) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing owed", result, '0);
			end else begin
				want = due_results.pop_front();
				compare_field("status",        result.status,        want.status);
				compare_field("issue_packet",  result.issue_packet,  want.issue_packet);
				compare_field("packet_length", result.packet_length, want.packet_length);
				compare_field("packet_pid",    result.packet_pid,    want.packet_pid);
				compare_field("packet_full",   result.packet_full,   want.packet_full);
				compare_field("packet_last",   result.packet_last,   want.packet_last);
				compare_field("transfer_done", result.transfer_done, want.transfer_done);
				compare_field("done_length",   result.done_length,   want.done_length);
				results_checked++;
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || cfg_wen)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d results still owed",
				$time, STALL_LIMIT, due_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Present one item and hold it until the block takes it; start stays high
	// so that a following item can go on the very next edge.
	task automatic send_item(input cmd_t item);
		start <= 1'b1;
		cmd   <= item;
		do @(posedge clk); while (busy !== 1'b0);
		due_results.push_back(segment_command(item));
		items_sent++;
	endtask

	task automatic send_cmd(input logic [OP_W-1:0] op, input int unsigned s,
			input int unsigned req, input int unsigned act);
		cmd_t item;
		item.operation      = op;
		item.endpoint_slot  = SLOT_W'(s);
		item.request_length = LEN_W'(req);
		item.actual_length  = PKT_W'(act);
		send_item(item);
	endtask

	// Drop start for a burst of idle cycles
	task automatic hold_off(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the packet size register with the block idle
	task automatic write_mps(input logic [PKT_W-1:0] value);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		mps_reg = value;
		mps_writes++;
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed transfers on a few hot slots: starts on idle slots,
	// packet-dones that report exactly the issued length, and now and then a
	// short or oversized packet, a refused start, a forced DATA1 or noise.
	task automatic run_traffic(input int unsigned count, input bit with_gaps);
		cmd_t        item;
		int unsigned hot [4];
		int unsigned s;
		int unsigned pick;
		foreach (hot[i])
			hot[i] = $urandom_range(0, NUM_SLOTS - 1);
		for (int unsigned n = 0; n < count; n++) begin
			// idle in bursts, with every other stretch of 50 items left dense
			if (with_gaps && (n / 50) % 2 == 0 && $urandom_range(0, 5) == 0)
				hold_off($urandom_range(1, 19));
			s    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_SLOTS - 1)
				: hot[$urandom_range(0, 3)];
			pick = $urandom_range(0, 19);
			item.endpoint_slot  = SLOT_W'(s);
			item.request_length = LEN_W'($urandom_range(0, 65535));
			item.actual_length  = PKT_W'($urandom_range(0, 127));
			if (slot_busy[s]) begin
				if (pick < 15) begin
					item.operation     = OP_PKT_DONE;
					item.actual_length = PKT_W'(next_packet_len(s));
				end else if (pick < 17) begin
					item.operation = OP_PKT_DONE;
				end else if (pick < 18) begin
					item.operation = OP_START;
				end else if (pick < 19) begin
					item.operation = OP_FORCE_DATA1;
				end else begin
					item.operation = OP_UNUSED;
				end
			end else begin
				if (pick < 14) begin
					item.operation = OP_START;
					// keep most transfers a few packets long
					if ($urandom_range(0, 9) != 0)
						item.request_length = LEN_W'($urandom_range(0, 4 * eff_packet() + 2));
				end else if (pick < 16) begin
					item.operation = OP_PKT_DONE;
				end else if (pick < 18) begin
					item.operation = OP_FORCE_DATA1;
				end else begin
					item.operation = OP_UNUSED;
				end
			end
			send_item(item);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corner cases one at a time, mostly at the reset packet size of 64
	task automatic test_directed();
		send_cmd(OP_START,       0, 0,     0);    // zero-length transfer, one empty packet
		send_cmd(OP_START,       0, 5,     0);    // refused: slot already busy
		send_cmd(OP_PKT_DONE,    0, 0,     0);    // empty packet completes it
		send_cmd(OP_PKT_DONE,    0, 0,     5);    // packet-done on an idle slot
		send_cmd(OP_FORCE_DATA1, 1, 0,     0);    // force on an idle slot
		send_cmd(OP_START,       1, 65535, 0);    // OUT slot, largest request, DATA1
		send_cmd(OP_PKT_DONE,    1, 0,     64);
		send_cmd(OP_PKT_DONE,    1, 0,     127);  // more than was issued
		send_cmd(OP_FORCE_DATA1, 1, 0,     0);    // force on a busy slot
		send_cmd(OP_PKT_DONE,    1, 0,     63);   // short packet ends it
		send_cmd(OP_UNUSED,      31, 65535, 127); // unused code, every bit set
		send_cmd(OP_START,       30, 128,  0);
		send_cmd(OP_PKT_DONE,    30, 0,    64);
		send_cmd(OP_PKT_DONE,    30, 0,    64);   // count reaches the request
		send_cmd(OP_START,       30, 100,  0);    // toggle carried over
		send_cmd(OP_PKT_DONE,    30, 0,    64);
		send_cmd(OP_PKT_DONE,    30, 0,    36);
		// register value 0 acts as a packet size of 1
		write_mps('0);
		send_cmd(OP_START,       2, 3,     0);
		send_cmd(OP_PKT_DONE,    2, 0,     1);
		send_cmd(OP_PKT_DONE,    2, 0,     0);
	endtask

	// Traffic under each packet size, the extremes among them
	task automatic test_packet_sizes();
		logic [PKT_W-1:0] sizes [6];
		sizes = '{7'd127, 7'd1, 7'd0, PKT_W'($urandom_range(2, 63)),
			PKT_W'($urandom_range(65, 126)), MPS_RESET};
		foreach (sizes[i]) begin
			write_mps(sizes[i]);
			run_traffic(60, 1'b1);
		end
	endtask

	// Push one transfer past 65535 bytes with oversized packets
	task automatic test_count_saturation();
		int unsigned s;
		s = 2 * $urandom_range(0, NUM_SLOTS / 2 - 1);
		if (slot_busy[s])
			send_cmd(OP_PKT_DONE, s, 0, 0);
		send_cmd(OP_START, s, 65535, 0);
		while (slot_busy[s]) begin
			if ($urandom_range(0, 15) == 0)
				hold_off($urandom_range(1, 19));
			send_cmd(OP_PKT_DONE, s, $urandom_range(0, 65535), $urandom_range(96, 127));
		end
	endtask

	// Long random run with a full pause halfway
	task automatic test_random_traffic();
		run_traffic(200, 1'b1);
		drain();
		run_traffic(200, 1'b1);
	endtask

	// Closing stretch with no idling at all
	task automatic test_back_to_back();
		run_traffic(200, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		clear_slot_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_packet_sizes();
		test_count_saturation();
		test_random_traffic();
		test_back_to_back();

		// wait for the tail, then a few cycles for anything stray
		drain();
		repeat (6) @(posedge clk);

		$display("Ran %0d items through %0d packet size settings; %0d results checked.",
			items_sent, mps_writes, results_checked);
		$display("Saw %0d completed transfers, %0d refused starts, %0d saturated counts.",
			transfers_done, starts_refused, counts_saturated);
		if (mismatches == 0 && due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
